### design/trpc_pkg.sv
`timescale 1ns / 1ps

package trpc_pkg;

   localparam int NUM_CHANNELS_DEF = 2;
   localparam int MAX_CHANNELS     = 8;
   localparam int PULSE_W          = 16;
   localparam int CHAN_W           = 3;
   localparam int MODE_W           = 3;

   // command codes
   localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_DROP    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DISABLE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_QUERY   = 3'd4;

   // result codes
   localparam logic [1:0] RES_OK      = 2'd0;
   localparam logic [1:0] RES_RUNNING = 2'd1;
   localparam logic [1:0] RES_FAILED  = 2'd2;

   // channel state codes
   localparam logic [1:0] ST_UNINIT   = 2'd0;
   localparam logic [1:0] ST_READY    = 2'd1;
   localparam logic [1:0] ST_DROPPING = 2'd2;
   localparam logic [1:0] ST_DROPPED  = 2'd3;

   typedef struct packed {
      logic tick;
      logic start;
      logic disable_all;
      logic clear;
   } trpc_chan_ctl_type;

   typedef struct packed {
      logic dropping;
      logic dropped;
      logic dropping_next;
   } trpc_chan_stat_type;

endpackage

### design/trpc_channel.sv
`timescale 1ns / 1ps

module trpc_channel (
   input  logic                             clock,
   input  logic                             reset,
   input  trpc_pkg::trpc_chan_ctl_type      ctl,
   input  logic [trpc_pkg::PULSE_W-1:0]     load_value,
   output trpc_pkg::trpc_chan_stat_type     stat
);

   logic                         dropping_ff, dropping_in;
   logic                         dropped_ff, dropped_in;
   logic [trpc_pkg::PULSE_W-1:0] ticks_ff, ticks_in;

   always_comb begin
      dropping_in = dropping_ff;
      dropped_in  = dropped_ff;
      ticks_in    = ticks_ff;
      if (ctl.tick && dropping_ff) begin
         if (ticks_ff <= trpc_pkg::PULSE_W'(1)) begin
            dropping_in = 1'b0;
            dropped_in  = 1'b1;
            ticks_in    = '0;
         end else begin
            ticks_in = ticks_ff - trpc_pkg::PULSE_W'(1);
         end
      end
      if (ctl.start) begin
         dropping_in = 1'b1;
         ticks_in    = load_value;
      end
      if (ctl.disable_all && dropping_ff) begin
         dropping_in = 1'b0;
         dropped_in  = 1'b1;
         ticks_in    = '0;
      end
      if (ctl.clear && !dropping_ff) begin
         dropped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dropping_ff <= 1'b0;
         dropped_ff  <= 1'b0;
         ticks_ff    <= '0;
      end else begin
         dropping_ff <= dropping_in;
         dropped_ff  <= dropped_in;
         ticks_ff    <= ticks_in;
      end
   end

   assign stat.dropping      = dropping_ff;
   assign stat.dropped       = dropped_ff;
   assign stat.dropping_next = dropping_in;

   // a running pulse never has a zero count left
   assert property (@(posedge clock) disable iff (reset)
      dropping_ff |-> ticks_ff != '0)
      else $error("dropping channel with zero ticks left");

   assert property (@(posedge clock) disable iff (reset)
      !(dropping_ff && dropped_ff))
      else $error("channel both dropping and dropped");

   assert property (@(posedge clock) disable iff (reset)
      ctl.start |=> dropping_ff && ticks_ff == $past(load_value))
      else $error("pulse start did not load count");

endmodule

### design/timed_release_pulse_controller.sv
`timescale 1ns / 1ps
// A word accepted from req waits in the input stage and goes to the result register
// once the output stage can advance; rsp_tvalid then offers its result word.
// Throughput: one word per cycle unless rsp_tready stalls; channels update in parallel.
// Reset (synchronous): all channels neither dropping nor dropped, pulse length 0, both stages empty.

module timed_release_pulse_controller #(
   parameter int NUM_CHANNELS = trpc_pkg::NUM_CHANNELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // mode[2:0], channel[5:3], kill_asserted[6], zero[7]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // result[1:0], channel_state[3:2], drive_lines[11:4], zero
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   logic [trpc_pkg::PULSE_W-1:0] pulse_ff;

   logic                         in_valid_ff;
   logic [trpc_pkg::MODE_W-1:0]  mode_ff;
   logic [trpc_pkg::CHAN_W-1:0]  chan_ff;
   logic                         kill_ff;

   logic                         out_valid_ff;
   logic [1:0]                   result_ff, result_in;
   logic [1:0]                   qstate_ff, qstate_in;
   logic [7:0]                   drive_ff, drive_in;

   logic                         advance_out, fire;

   trpc_pkg::trpc_chan_ctl_type  ctl  [NUM_CHANNELS];
   trpc_pkg::trpc_chan_stat_type stat [NUM_CHANNELS];

   logic [7:0]                   dropping8, dropped8;
   logic [trpc_pkg::CHAN_W-1:0]  chan_idx;
   logic                         chan_ok;
   logic [1:0]                   sel_state;
   logic                         any_dropping;
   logic                         do_start;
   logic [NUM_CHANNELS-1:0]      start_vec;

   assign advance_out = !out_valid_ff || rsp_tready;
   assign fire        = in_valid_ff && advance_out;
   assign req_tready  = !in_valid_ff || advance_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ff <= '0;
      end else if (csr_we) begin
         pulse_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         mode_ff <= req_tdata[2:0];
         chan_ff <= req_tdata[5:3];
         kill_ff <= req_tdata[6];
      end
   end

   always_comb begin
      dropping8 = '0;
      dropped8  = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         dropping8[i] = stat[i].dropping;
         dropped8[i]  = stat[i].dropped;
      end
   end

   assign any_dropping = |dropping8;
   assign chan_idx     = chan_ff - trpc_pkg::CHAN_W'(1);
   assign chan_ok      = (chan_ff != '0) && ({1'b0, chan_ff} <= 4'(NUM_CHANNELS));

   always_comb begin
      if (pulse_ff == '0) begin
         sel_state = trpc_pkg::ST_UNINIT;
      end else if (dropping8[chan_idx]) begin
         sel_state = trpc_pkg::ST_DROPPING;
      end else if (dropped8[chan_idx]) begin
         sel_state = trpc_pkg::ST_DROPPED;
      end else begin
         sel_state = trpc_pkg::ST_READY;
      end
   end

   always_comb begin
      result_in = trpc_pkg::RES_OK;
      qstate_in = trpc_pkg::ST_UNINIT;
      do_start  = 1'b0;
      case (mode_ff)
         trpc_pkg::MODE_TICK: begin
            result_in = trpc_pkg::RES_OK;
         end
         trpc_pkg::MODE_DROP: begin
            if (!chan_ok || kill_ff) begin
               result_in = trpc_pkg::RES_FAILED;
            end else begin
               case (sel_state)
                  trpc_pkg::ST_DROPPED:  result_in = trpc_pkg::RES_OK;
                  trpc_pkg::ST_DROPPING: result_in = trpc_pkg::RES_RUNNING;
                  trpc_pkg::ST_READY: begin
                     result_in = trpc_pkg::RES_RUNNING;
                     do_start  = 1'b1;
                  end
                  default:               result_in = trpc_pkg::RES_FAILED;
               endcase
            end
         end
         trpc_pkg::MODE_CLEAR: begin
            result_in = any_dropping ? trpc_pkg::RES_FAILED : trpc_pkg::RES_OK;
         end
         trpc_pkg::MODE_DISABLE: begin
            result_in = trpc_pkg::RES_OK;
         end
         trpc_pkg::MODE_QUERY: begin
            if (!chan_ok) begin
               result_in = trpc_pkg::RES_FAILED;
            end else begin
               qstate_in = sel_state;
            end
         end
         default: begin
            result_in = trpc_pkg::RES_FAILED;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         start_vec[i]          = fire && do_start && (chan_idx == trpc_pkg::CHAN_W'(i));
         ctl[i].tick           = fire && (mode_ff == trpc_pkg::MODE_TICK);
         ctl[i].start          = start_vec[i];
         ctl[i].disable_all    = fire && (mode_ff == trpc_pkg::MODE_DISABLE);
         ctl[i].clear          = fire && (mode_ff == trpc_pkg::MODE_CLEAR);
      end
   end

   always_comb begin
      drive_in = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         drive_in[i] = stat[i].dropping_next;
      end
   end

   for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_chan
      trpc_channel u_chan (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl[g]),
         .load_value (pulse_ff),
         .stat       (stat[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance_out) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         result_ff <= result_in;
         qstate_ff <= qstate_in;
         drive_ff  <= drive_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0, drive_ff, qstate_ff, result_ff};

   assert property (@(posedge clock) disable iff (reset)
      $countones(start_vec) <= 1)
      else $error("more than one channel started by one word");

   assert property (@(posedge clock) disable iff (reset)
      (start_vec != '0) |-> pulse_ff != '0)
      else $error("pulse started with unset length");

   assert property (@(posedge clock) disable iff (reset)
      fire && mode_ff == trpc_pkg::MODE_DISABLE |=> dropping8 == '0)
      else $error("safety disable left a channel dropping");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> result_ff != 2'd3)
      else $error("illegal result code");

endmodule

### bench/release_checker.sv
`timescale 1ns / 1ps

module release_checker #(
   parameter int NCH = trpc_pkg::NUM_CHANNELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // mode[2:0], channel[5:3], kill_asserted[6], zero[7]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // result[1:0], channel_state[3:2], drive_lines[11:4], zero
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic [7:0] drive;
      logic [1:0] state;
      logic [1:0] result;
   } reply_type;

   reply_type         expected_replies[$];
   logic [15:0]       pulse_len;
   logic [NCH-1:0]    dropping;
   logic [NCH-1:0]    dropped;
   logic [15:0]       ticks_left [NCH];
   int                fails;

   function automatic logic [1:0] chan_state(input int i);
      if (pulse_len == '0) return trpc_pkg::ST_UNINIT;
      if (dropping[i]) return trpc_pkg::ST_DROPPING;
      if (dropped[i]) return trpc_pkg::ST_DROPPED;
      return trpc_pkg::ST_READY;
   endfunction

   function automatic logic [7:0] drive_mask();
      logic [7:0] m;
      m = '0;
      for (int i = 0; i < NCH && i < 8; i++) m[i] = dropping[i];
      return m;
   endfunction

   task automatic finish_pulse(input int i);
      dropping[i]   = 1'b0;
      dropped[i]    = 1'b1;
      ticks_left[i] = '0;
   endtask

   // Applies one command word to the shadow state and returns the reply it must produce.
   task automatic apply_command(input logic [7:0] word, output reply_type r);
      logic [2:0] mode;
      logic [2:0] ch;
      logic       kill;
      logic       ch_ok;
      int         idx;
      mode  = word[2:0];
      ch    = word[5:3];
      kill  = word[6];
      ch_ok = (ch >= 1) && (ch <= NCH);
      idx   = int'(ch) - 1;
      r     = '0;
      r.result = trpc_pkg::RES_OK;
      case (mode)
         trpc_pkg::MODE_TICK: begin
            for (int i = 0; i < NCH; i++) begin
               if (dropping[i]) begin
                  if (ticks_left[i] <= 16'd1) finish_pulse(i);
                  else ticks_left[i] = ticks_left[i] - 16'd1;
               end
            end
         end
         trpc_pkg::MODE_DROP: begin
            if (!ch_ok || kill) begin
               r.result = trpc_pkg::RES_FAILED;
            end else begin
               case (chan_state(idx))
                  trpc_pkg::ST_DROPPED:  r.result = trpc_pkg::RES_OK;
                  trpc_pkg::ST_DROPPING: r.result = trpc_pkg::RES_RUNNING;
                  trpc_pkg::ST_READY: begin
                     dropping[idx]   = 1'b1;
                     ticks_left[idx] = pulse_len;
                     r.result        = trpc_pkg::RES_RUNNING;
                  end
                  default:     r.result = trpc_pkg::RES_FAILED;
               endcase
            end
         end
         trpc_pkg::MODE_CLEAR: begin
            for (int i = 0; i < NCH; i++) begin
               if (dropping[i]) r.result = trpc_pkg::RES_FAILED;
               else dropped[i] = 1'b0;
            end
         end
         trpc_pkg::MODE_DISABLE: begin
            for (int i = 0; i < NCH; i++) if (dropping[i]) finish_pulse(i);
         end
         trpc_pkg::MODE_QUERY: begin
            if (!ch_ok) r.result = trpc_pkg::RES_FAILED;
            else r.state = chan_state(idx);
         end
         default: r.result = trpc_pkg::RES_FAILED;
      endcase
      r.drive = drive_mask();
   endtask

   always @(posedge clock) begin
      reply_type want;
      reply_type got;
      reply_type next;
      if (reset) begin
         expected_replies.delete();
         pulse_len = '0;
         dropping  = '0;
         dropped   = '0;
         for (int i = 0; i < NCH; i++) ticks_left[i] = '0;
         fails = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[11:0];
            if (expected_replies.size() == 0) begin
               $error("reply word with no command waiting: %h", rsp_tdata);
               fails++;
            end else begin
               want = expected_replies.pop_front();
               if (got.result !== want.result) begin
                  $error("result: expected %0d, actual %0d", want.result, got.result);
                  fails++;
               end
               if (got.state !== want.state) begin
                  $error("channel_state: expected %0d, actual %0d", want.state, got.state);
                  fails++;
               end
               if (got.drive !== want.drive) begin
                  $error("drive_lines: expected %h, actual %h", want.drive, got.drive);
                  fails++;
               end
            end
         end
         if (csr_we) pulse_len = csr_wdata;
         if (req_tvalid && req_tready) begin
            apply_command(req_tdata, next);
            expected_replies.push_back(next);
         end
      end
      fail_count <= fails;
      pending    <= expected_replies.size();
   end

endmodule

### bench/tb_timed_release_pulse_controller.sv
`timescale 1ns / 1ps

module tb_timed_release_pulse_controller;

   localparam int          NCH            = trpc_pkg::NUM_CHANNELS_DEF;
   localparam logic [2:0]  MODE_SPARE_LO  = 3'd5;
   localparam logic [2:0]  MODE_SPARE_MID = 3'd6;
   localparam logic [2:0]  MODE_SPARE_HI  = 3'd7;
   localparam int          PHASES         = 8;
   localparam int          PHASE_ITEMS    = 94;
   localparam int          HOLD_AT_WORD   = 300;
   localparam int          HOLD_CYCLES    = 80;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        csr_we;
   logic [15:0] csr_wdata;
   int          fail_count;
   int          pending;

   bit          req_calm;
   int unsigned words_out;
   int unsigned rsp_wait;
   int unsigned hold_left;

   timed_release_pulse_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   release_checker #(.NCH(NCH)) chk (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("timed_release_pulse_controller verification failed");
      $finish;
   end

   // Receiver: random stall after each word, calm stretches, and one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait  = 0;
         hold_left = 0;
         words_out = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            words_out++;
            rsp_wait = ((words_out / 100) % 3 == 1) ? 0 : $urandom_range(0, 9);
            if (words_out == HOLD_AT_WORD) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // valid is only dropped when a gap follows, so back-to-back words never glitch it
   task automatic send_word(input logic [2:0] mode, input logic [2:0] ch, input logic kill);
      int unsigned gap;
      gap = req_calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, kill, ch, mode};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic load_pulse_length(input logic [15:0] v);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic send_random_word();
      int unsigned roll;
      logic [2:0]  any_ch;
      logic [2:0]  good_ch;
      logic        kill;
      roll    = $urandom_range(0, 99);
      any_ch  = 3'($urandom_range(0, 7));
      good_ch = 3'($urandom_range(1, NCH));
      kill    = ($urandom_range(0, 15) == 0);
      if (roll < 40)      send_word(trpc_pkg::MODE_TICK, any_ch, kill);
      else if (roll < 65) send_word(trpc_pkg::MODE_DROP, good_ch, kill);
      else if (roll < 78) send_word(trpc_pkg::MODE_QUERY, good_ch, kill);
      else if (roll < 85) send_word(trpc_pkg::MODE_CLEAR, any_ch, kill);
      else if (roll < 89) send_word(trpc_pkg::MODE_DISABLE, any_ch, kill);
      else if (roll < 92) send_word(trpc_pkg::MODE_DROP, any_ch, kill);
      else if (roll < 95) send_word(trpc_pkg::MODE_QUERY, any_ch, kill);
      else send_word(3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)), any_ch, kill);
   endtask

   initial begin
      logic [15:0] phase_len [PHASES];
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_wdata  <= '0;
      req_calm   = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // timings unset
      send_word(trpc_pkg::MODE_QUERY, 3'd1, 1'b0);
      send_word(trpc_pkg::MODE_DROP, 3'd1, 1'b0);
      send_word(trpc_pkg::MODE_TICK, 3'd7, 1'b1);
      send_word(MODE_SPARE_LO, 3'd2, 1'b0);
      send_word(MODE_SPARE_MID, 3'd0, 1'b1);
      send_word(MODE_SPARE_HI, 3'd7, 1'b0);

      load_pulse_length(16'd3);
      send_word(trpc_pkg::MODE_DROP, 3'd0, 1'b0);
      send_word(trpc_pkg::MODE_DROP, 3'd7, 1'b0);
      send_word(trpc_pkg::MODE_DROP, 3'd1, 1'b1);
      send_word(trpc_pkg::MODE_DROP, 3'd1, 1'b0);
      send_word(trpc_pkg::MODE_DROP, 3'd1, 1'b0);
      send_word(trpc_pkg::MODE_QUERY, 3'd1, 1'b0);
      send_word(trpc_pkg::MODE_QUERY, 3'd0, 1'b0);
      send_word(trpc_pkg::MODE_CLEAR, 3'd0, 1'b0);
      repeat (3) send_word(trpc_pkg::MODE_TICK, 3'd0, 1'b0);
      send_word(trpc_pkg::MODE_DROP, 3'd1, 1'b0);
      send_word(trpc_pkg::MODE_QUERY, 3'd1, 1'b0);
      send_word(trpc_pkg::MODE_DROP, 3'd2, 1'b0);
      send_word(trpc_pkg::MODE_CLEAR, 3'd0, 1'b0);   // fails, ch2 still running
      send_word(trpc_pkg::MODE_DISABLE, 3'd0, 1'b0);
      send_word(trpc_pkg::MODE_QUERY, 3'd2, 1'b0);
      send_word(trpc_pkg::MODE_CLEAR, 3'd0, 1'b0);

      // longest pulse, then shrink the register under it
      load_pulse_length(16'hFFFF);
      send_word(trpc_pkg::MODE_DROP, 3'd1, 1'b0);
      send_word(trpc_pkg::MODE_TICK, 3'd0, 1'b0);
      load_pulse_length(16'd1);
      send_word(trpc_pkg::MODE_DROP, 3'd2, 1'b0);
      send_word(trpc_pkg::MODE_TICK, 3'd0, 1'b0);
      send_word(trpc_pkg::MODE_QUERY, 3'd1, 1'b0);

      phase_len[0] = 16'd1;
      phase_len[1] = 16'd2;
      phase_len[2] = 16'($urandom_range(1, 12));
      phase_len[3] = 16'd0;
      phase_len[4] = 16'hFFFF;
      phase_len[5] = 16'd4;
      phase_len[6] = 16'($urandom_range(1, 30));
      phase_len[7] = 16'd7;
      for (int p = 0; p < PHASES; p++) begin
         load_pulse_length(phase_len[p]);
         req_calm = (p % 3 == 2);
         repeat (PHASE_ITEMS) send_random_word();
      end

      drain();
      if (fail_count == 0 && pending == 0) begin
         $display("timed_release_pulse_controller verification clean");
      end else begin
         $display("timed_release_pulse_controller verification failed");
      end
      $finish;
   end

endmodule
